// ===== rtl/core/bsig_pkg.sv =====
// Shared constants and types for the best-split gain core.
package bsig_pkg;

    localparam int MaxItems   = 4096;
    localparam int SplitSteps = 10;
    localparam int ScoreBits  = 16;
    localparam int NumSplits  = SplitSteps + 1;
    localparam int AddrBits   = $clog2(MaxItems);
    localparam int CntBits    = $clog2(MaxItems + 1);
    localparam int SplitBits  = $clog2(NumSplits + 1);
    localparam int GainBits   = 17;
    localparam int GainMax    = 65536;
    localparam int LogBits    = CntBits + 16;
    localparam int FBits      = CntBits + LogBits;
    localparam int LogWBits   = $clog2(CntBits) + 16;
    localparam int MulBits    = CntBits + LogWBits;
    localparam int ProdBits   = ScoreBits + SplitBits;
    localparam int DivShift   = ProdBits + $clog2(SplitSteps);
    localparam int DivRecip   = ((1 << DivShift) + SplitSteps - 1) / SplitSteps;
    localparam int DivSteps   = GainBits + 1;
    localparam int DStepBits  = $clog2(DivSteps + 1);
    localparam int QDepth     = 4;
    localparam int QPtrBits   = $clog2(QDepth);

    typedef logic [ScoreBits-1:0] t_score;
    typedef logic [CntBits-1:0]   t_cnt;
    typedef logic [GainBits-1:0]  t_gain;

    typedef struct packed {
        t_score score;
        logic   pos;
        logic   last;
    } t_item;

endpackage

// ===== rtl/core/best_split_information_gain_core.sv =====
// Top level of the best-split information gain core.
//  channel  | dir | handshake      | beat
//  input    | in  | push / full    | score_value, is_positive, last_item
//  result   | out | pop / empty    | best_gain, set_overflow
// Items load at one per cycle via a four-entry queue into a 4096-entry store; push stalls
// on full while the engine is busy. After the last item each of the eleven thresholds
// scans the store, takes six log2 terms, divides and updates the best gain; the first
// threshold adds three terms for the whole set. An empty set or zero range answers at once.
// Reset is synchronous; no clearing pass is needed. A waiting result holds the engine.
module best_split_information_gain_core
    import bsig_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        push,
    output logic        full,
    input  logic [15:0] i_score_value,
    input  logic        i_is_positive,
    input  logic        i_last_item,
    output logic        empty,
    input  logic        pop,
    output logic [16:0] o_best_gain,
    output logic        o_set_overflow
);

    t_item w_in;
    t_item w_q;
    logic  w_qv;
    logic  w_take;
    logic  w_rv;

    assign w_in = '{score: i_score_value, pos: i_is_positive, last: i_last_item};

    bsig_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_item  (w_in),
        .o_full  (full),
        .o_valid (w_qv),
        .o_item  (w_q),
        .i_take  (w_take)
    );

    bsig_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (w_qv),
        .i_item      (w_q),
        .o_take      (w_take),
        .o_res_valid (w_rv),
        .o_gain      (o_best_gain),
        .o_ovf       (o_set_overflow),
        .i_res_taken (pop)
    );

    assign empty = !w_rv;

endmodule

// ===== rtl/core/bsig_log2.sv =====
// Iterative log2 unit in Q.16 that returns n times log2(n), one squaring per cycle.
module bsig_log2
    import bsig_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_start,
    input  t_cnt               i_n,
    output logic               o_done,
    output logic [FBits-1:0]   o_f
);

    typedef enum logic [1:0] {S_IDLE, S_NORM, S_SQ, S_MUL} t_state;

    t_state                 r_state;
    logic [31:0]            r_m;
    logic [15:0]            r_frac;
    logic [4:0]             r_step;
    logic [$clog2(CntBits)-1:0] r_e;
    t_cnt                   r_n;
    logic [FBits-1:0]       r_f;
    logic                   r_done;
    logic [63:0]            w_sq;
    logic [31:0]            w_msh;

    assign w_sq  = 64'(r_m) * 64'(r_m);
    assign w_msh = w_sq[61:30];

    always_ff @(posedge i_clk) begin
        r_done <= 1'b0;
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            case (r_state)
                S_IDLE: begin
                    if (i_start) begin
                        r_n     <= i_n;
                        r_e     <= '0;
                        r_frac  <= '0;
                        r_step  <= '0;
                        r_state <= S_NORM;
                    end
                end
                S_NORM: begin
                    if (r_n < t_cnt'(2)) begin
                        r_f     <= '0;
                        r_done  <= 1'b1;
                        r_state <= S_IDLE;
                    end else if ((r_n >> (r_e + 1'b1)) != '0) begin
                        r_e <= r_e + 1'b1;
                    end else begin
                        r_m     <= 32'((62'(r_n) << 30) >> r_e);
                        r_state <= S_SQ;
                    end
                end
                S_SQ: begin
                    if (w_msh[31]) begin
                        r_m    <= {1'b0, w_msh[31:1]};
                        r_frac <= {r_frac[14:0], 1'b1};
                    end else begin
                        r_m    <= w_msh;
                        r_frac <= {r_frac[14:0], 1'b0};
                    end
                    r_step <= r_step + 1'b1;
                    if (r_step == 5'd15) begin
                        r_state <= S_MUL;
                    end
                end
                S_MUL: begin
                    r_f     <= FBits'(MulBits'(r_n) * MulBits'({r_e, r_frac}));
                    r_done  <= 1'b1;
                    r_state <= S_IDLE;
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_done = r_done;
    assign o_f    = r_f;

endmodule

// ===== rtl/core/bsig_front.sv =====
// Front end: takes items and queues them for the evaluation engine.
module bsig_front
    import bsig_pkg::*;
(
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_push,
    input  t_item i_item,
    output logic  o_full,
    output logic  o_valid,
    output t_item o_item,
    input  logic  i_take
);

    t_item             r_q [QDepth];
    logic [QPtrBits-1:0] r_wp;
    logic [QPtrBits-1:0] r_rp;
    logic [QPtrBits:0]   r_cnt;
    logic              w_push;
    logic              w_take;

    assign o_full  = (r_cnt == (QPtrBits+1)'(QDepth));
    assign o_valid = (r_cnt != '0);
    assign o_item  = r_q[r_rp];
    assign w_push  = i_push && !o_full;
    assign w_take  = i_take && o_valid;

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_q[r_wp] <= i_item;
        end
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (w_push) begin
                r_wp <= r_wp + 1'b1;
            end
            if (w_take) begin
                r_rp <= r_rp + 1'b1;
            end
            r_cnt <= r_cnt + (QPtrBits+1)'(w_push) - (QPtrBits+1)'(w_take);
        end
    end

endmodule

// ===== rtl/core/bsig_back.sv =====
// Back end: stores the set, counts each threshold and finds the largest gain.
module bsig_back
    import bsig_pkg::*;
(
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_valid,
    input  t_item i_item,
    output logic  o_take,
    output logic  o_res_valid,
    output t_gain o_gain,
    output logic  o_ovf,
    input  logic  i_res_taken
);

    typedef enum logic [3:0] {
        S_LOAD, S_THR, S_SCAN, S_DRAIN, S_LW, S_LB, S_LA, S_DIV, S_NEXT, S_OUT
    } t_state;

    logic [ScoreBits:0]   r_mem [MaxItems];
    t_state               r_state;
    t_cnt                 r_n;
    t_cnt                 r_p;
    t_score               r_min;
    t_score               r_max;
    logic                 r_ovf;
    t_gain                r_best;
    logic [SplitBits-1:0] r_j;
    logic [ProdBits-1:0]  r_prod;
    logic [ScoreBits:0]   r_thr;
    t_cnt                 r_i;
    logic [ScoreBits:0]   r_rd;
    logic                 r_rdv;
    t_cnt                 r_bp;
    t_cnt                 r_bn;
    logic signed [FBits+1:0] r_whole;
    logic signed [FBits+1:0] r_d;
    logic [1:0]           r_sub;
    logic                 r_have_whole;
    logic [FBits+1:0]     r_rem;
    logic [FBits+1:0]     r_dvs;
    logic [GainBits:0]    r_quo;
    logic [DStepBits-1:0] r_dstep;
    logic                 r_lstart;
    t_cnt                 r_ln;
    logic                 r_resv;
    logic                 w_ldone;
    logic [FBits-1:0]     w_lf;
    logic [ProdBits+DivShift-1:0] w_scaled;
    logic [FBits+2:0]     w_trial;
    logic                 w_hit;
    t_gain                w_g;

    bsig_log2 u_log (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (r_lstart),
        .i_n     (r_ln),
        .o_done  (w_ldone),
        .o_f     (w_lf)
    );

    assign o_take      = (r_state == S_LOAD) && i_valid;
    assign o_res_valid = r_resv;
    assign o_gain      = r_best;
    assign o_ovf       = r_ovf;
    assign w_scaled    = (ProdBits+DivShift)'(r_prod) * (ProdBits+DivShift)'(DivRecip);
    assign w_trial     = {1'b0, r_rem} - {1'b0, r_dvs};
    assign w_hit       = (ScoreBits+1)'(r_rd[ScoreBits:1]) < r_thr;
    assign w_g         = (r_quo > (GainBits+1)'(GainMax)) ? t_gain'(GainMax)
                                                          : r_quo[GainBits-1:0];

    always_ff @(posedge i_clk) begin
        r_rd <= r_mem[r_i[AddrBits-1:0]];
        if (o_take && (r_n < t_cnt'(MaxItems))) begin
            r_mem[r_n[AddrBits-1:0]] <= {i_item.score, i_item.pos};
        end
        r_lstart <= 1'b0;
        if (!i_rst_n) begin
            r_state <= S_LOAD;
            r_n     <= '0;
            r_p     <= '0;
            r_min   <= '1;
            r_max   <= '0;
            r_ovf   <= 1'b0;
            r_best  <= '0;
            r_resv  <= 1'b0;
            r_rdv   <= 1'b0;
        end else begin
            case (r_state)
                S_LOAD: begin
                    if (o_take) begin
                        if (r_n < t_cnt'(MaxItems)) begin
                            r_n <= r_n + 1'b1;
                            r_p <= r_p + t_cnt'(i_item.pos);
                            if (i_item.score < r_min) r_min <= i_item.score;
                            if (i_item.score > r_max) r_max <= i_item.score;
                        end else begin
                            r_ovf <= 1'b1;
                        end
                        if (i_item.last) begin
                            r_state <= S_THR;
                            r_j     <= '0;
                            r_prod  <= '0;
                            r_best  <= '0;
                            r_have_whole <= 1'b0;
                        end
                    end
                end
                S_THR: begin
                    if ((r_n == '0) || (r_min >= r_max) || (r_j == SplitBits'(NumSplits))) begin
                        r_resv  <= 1'b1;
                        r_state <= S_OUT;
                    end else begin
                        r_thr   <= (ScoreBits+1)'(r_min) + w_scaled[DivShift +: ScoreBits+1];
                        r_i     <= '0;
                        r_bp    <= '0;
                        r_bn    <= '0;
                        r_rdv   <= 1'b0;
                        r_state <= S_SCAN;
                    end
                end
                S_SCAN: begin
                    if (r_rdv && w_hit) begin
                        if (r_rd[0]) r_bp <= r_bp + 1'b1;
                        else         r_bn <= r_bn + 1'b1;
                    end
                    r_rdv <= 1'b1;
                    r_i   <= r_i + 1'b1;
                    if (r_i == r_n - 1'b1) begin
                        r_state <= S_DRAIN;
                    end
                end
                S_DRAIN: begin
                    if (w_hit) begin
                        if (r_rd[0]) r_bp <= r_bp + 1'b1;
                        else         r_bn <= r_bn + 1'b1;
                    end
                    r_sub    <= '0;
                    r_lstart <= 1'b1;
                    if (!r_have_whole) begin
                        r_ln    <= r_n;
                        r_state <= S_LW;
                    end else begin
                        r_d     <= r_whole;
                        r_ln    <= r_bp + r_bn + t_cnt'(w_hit);
                        r_state <= S_LB;
                    end
                end
                S_LW: begin
                    if (w_ldone) begin
                        case (r_sub)
                            2'd0: begin
                                r_whole <= (FBits+2)'(w_lf);
                                r_ln <= r_p;
                            end
                            2'd1: begin
                                r_whole <= r_whole - (FBits+2)'(w_lf);
                                r_ln <= r_n - r_p;
                            end
                            default: begin
                                r_whole <= r_whole - (FBits+2)'(w_lf);
                            end
                        endcase
                        if (r_sub == 2'd2) begin
                            r_have_whole <= 1'b1;
                            r_sub    <= '0;
                            r_d      <= r_whole - (FBits+2)'(w_lf);
                            r_ln     <= r_bp + r_bn;
                            r_state  <= S_LB;
                        end else begin
                            r_sub <= r_sub + 1'b1;
                        end
                        r_lstart <= 1'b1;
                    end
                end
                S_LB: begin
                    if (w_ldone) begin
                        r_lstart <= 1'b1;
                        case (r_sub)
                            2'd0: begin
                                r_d   <= r_d - (FBits+2)'(w_lf);
                                r_ln  <= r_bp;
                                r_sub <= 2'd1;
                            end
                            2'd1: begin
                                r_d   <= r_d + (FBits+2)'(w_lf);
                                r_ln  <= r_bn;
                                r_sub <= 2'd2;
                            end
                            2'd2: begin
                                r_d  <= r_d + (FBits+2)'(w_lf);
                                r_ln <= r_n - r_bp - r_bn;
                                r_sub <= '0;
                                r_state <= S_LA;
                            end
                            default: r_sub <= '0;
                        endcase
                    end
                end
                S_LA: begin
                    if (w_ldone) begin
                        case (r_sub)
                            2'd0: begin
                                r_lstart <= 1'b1;
                                r_d   <= r_d - (FBits+2)'(w_lf);
                                r_ln  <= r_p - r_bp;
                                r_sub <= 2'd1;
                            end
                            2'd1: begin
                                r_lstart <= 1'b1;
                                r_d   <= r_d + (FBits+2)'(w_lf);
                                r_ln  <= (r_n - r_p) - r_bn;
                                r_sub <= 2'd2;
                            end
                            default: begin
                                r_d      <= r_d + (FBits+2)'(w_lf);
                                r_dstep  <= '0;
                                r_state  <= S_DIV;
                            end
                        endcase
                    end
                end
                S_DIV: begin
                    if (r_dstep == '0) begin
                        r_rem   <= r_d[FBits+1] ? '0 : unsigned'(r_d);
                        r_dvs   <= (FBits+2)'(r_n) << GainBits;
                        r_quo   <= '0;
                        r_dstep <= r_dstep + 1'b1;
                    end else begin
                        if (!w_trial[FBits+2]) begin
                            r_rem <= w_trial[FBits+1:0];
                            r_quo <= {r_quo[GainBits-1:0], 1'b1};
                        end else begin
                            r_quo <= {r_quo[GainBits-1:0], 1'b0};
                        end
                        r_dvs   <= r_dvs >> 1;
                        r_dstep <= r_dstep + 1'b1;
                        if (r_dstep == DStepBits'(DivSteps)) begin
                            r_state <= S_NEXT;
                        end
                    end
                end
                S_NEXT: begin
                    if (w_g > r_best) begin
                        r_best <= w_g;
                    end
                    r_prod  <= r_prod + ProdBits'(r_max - r_min);
                    r_state <= S_THR;
                    r_j     <= r_j + 1'b1;
                end
                S_OUT: begin
                    if (i_res_taken) begin
                        r_resv  <= 1'b0;
                        r_n     <= '0;
                        r_p     <= '0;
                        r_min   <= '1;
                        r_max   <= '0;
                        r_ovf   <= 1'b0;
                        r_state <= S_LOAD;
                    end
                end
                default: r_state <= S_LOAD;
            endcase
        end
    end

endmodule

// ===== rtl/core/bsig_checker.sv =====
// Port-level checker for the best-split information gain core, with its bind.
module bsig_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        push,
    input logic        full,
    input logic        empty,
    input logic        pop,
    input logic [16:0] o_best_gain,
    input logic        o_set_overflow
);

    a_gain_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !empty |-> (o_best_gain <= 17'd65536)) else $error("gain out of range");
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && !pop) |=> (!empty && $stable(o_best_gain))) else $error("result changed");
    a_pop_empties: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && pop) |=> empty) else $error("result repeated");
    a_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> (empty && !full)) else $error("bad reset state");

endmodule

bind best_split_information_gain_core bsig_checker u_chk (.*);
